// File: sv/ones_complement_checksum_engine_macros.svh
// Assertion macros for the ones-complement checksum engine checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ONES_COMPLEMENT_CHECKSUM_ENGINE_MACROS_SVH
`define ONES_COMPLEMENT_CHECKSUM_ENGINE_MACROS_SVH

// Same-cycle implication: when a holds, b holds too.
`define OCCE_ASSERT_SAME(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("occe checker: same-cycle property failed");

// Next-cycle implication: when a holds, b holds in the cycle after.
`define OCCE_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("occe checker: next-cycle property failed");

// Delayed implication: when a holds, b is checked at a later sample.
`define OCCE_ASSERT_TWO(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> ##2 (b)) \
        else $error("occe checker: two-cycle property failed");

`endif

// File: sv/occe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occe_pkg
// Types, register map codes and the end-around-carry adder shared by the
// ones-complement checksum engine.
// ----------------------------------------------------------------------------
package occe_pkg;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register map (word offsets)
    localparam logic [5:0] OFS_CONFIG = 6'd0;
    localparam logic [5:0] OFS_DATA   = 6'd1;
    localparam logic [5:0] OFS_OUT    = 6'd2;

    // Config register bits
    localparam int CFG_CLEAR_BIT = 0;
    localparam int CFG_SWAP_BIT  = 1;

    // Accumulator start value
    localparam logic [15:0] SUM_INIT = 16'hFFFF;

    // One bus access as it travels from the input register to the core
    typedef struct packed {
        logic        operation;
        logic [5:0]  word_offset;
        logic [31:0] write_data;
    } t_item;

    // One access result
    typedef struct packed {
        logic [15:0] read_data;
        logic        bad_offset;
    } t_result;

    // 16-bit ones-complement add; a single fold of the carry cannot overflow
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: sv/occe_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occe_in_stage
// Input register: captures one bus access word and holds it until the core
// passes it on to the result register.
// ----------------------------------------------------------------------------
module occe_in_stage
    import occe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_drain,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Track occupancy: fill on load, empty on drain without refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the payload of an accepted word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/occe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occe_core
// Checksum state and register decode. Works out the result of the held
// access and updates swap mode, accumulator and pending byte when the access
// advances.
// ----------------------------------------------------------------------------
module occe_core
    import occe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic        r_swap;
    logic [15:0] r_sum;
    logic [7:0]  r_held;
    logic        r_held_valid;

    logic        n_swap;
    logic [15:0] n_sum;
    logic [7:0]  n_held;
    logic        n_held_valid;

    logic [7:0]  data_byte;
    logic [15:0] pair_word;
    logic [15:0] partial_word;
    logic [15:0] partial_sum;
    logic        is_bad;

    assign data_byte    = i_item.write_data[7:0];
    assign pair_word    = r_swap ? {r_held, data_byte} : {data_byte, r_held};
    assign partial_word = r_swap ? {r_held, 8'h00} : {8'h00, r_held};
    assign partial_sum  = r_held_valid ? ones_add(r_sum, partial_word) : r_sum;
    assign is_bad       = (i_item.word_offset != OFS_CONFIG) &&
                          (i_item.word_offset != OFS_DATA) &&
                          (i_item.word_offset != OFS_OUT);

    // Decode the access: read value and next state
    always_comb begin
        n_swap       = r_swap;
        n_sum        = r_sum;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        o_result     = '0;
        if (is_bad) begin
            o_result.bad_offset = 1'b1;
        end else if (i_item.operation == OP_READ) begin
            case (i_item.word_offset)
                OFS_CONFIG: o_result.read_data = r_swap ? 16'h0002 : 16'h0000;
                OFS_OUT:    o_result.read_data = partial_sum;
                default:    o_result.read_data = 16'h0000;
            endcase
        end else begin
            case (i_item.word_offset)
                OFS_CONFIG: begin
                    n_swap = i_item.write_data[CFG_SWAP_BIT];
                    if (i_item.write_data[CFG_CLEAR_BIT]) begin
                        n_sum        = SUM_INIT;
                        n_held       = 8'h00;
                        n_held_valid = 1'b0;
                    end
                end
                OFS_DATA: begin
                    if (!r_held_valid) begin
                        n_held       = data_byte;
                        n_held_valid = 1'b1;
                    end else begin
                        n_sum        = ones_add(r_sum, pair_word);
                        n_held       = 8'h00;
                        n_held_valid = 1'b0;
                    end
                end
                default: begin
                    n_swap = r_swap;
                end
            endcase
        end
    end

    // Commit state as the access moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap       <= 1'b0;
            r_sum        <= SUM_INIT;
            r_held       <= 8'h00;
            r_held_valid <= 1'b0;
        end else if (i_advance) begin
            r_swap       <= n_swap;
            r_sum        <= n_sum;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

// File: sv/occe_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occe_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module occe_out_stage
    import occe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_take,
    input  t_result i_result,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Track occupancy: fill on load, empty when taken without refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture a new result word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: sv/ones_complement_checksum_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ones_complement_checksum_engine
// Register-mapped 16-bit ones-complement checksum engine, one result per
// bus access.
// ----------------------------------------------------------------------------
// Each accepted access word passes through an input register and a result
// register; its result is taken from there when the output is not stalled.
// The engine takes one access every cycle while the output is not stalled:
// the only logic between the two registers is the register decode and one
// 16-bit end-around-carry add. Accesses update the checksum state in order,
// so a read of the output register sees every data byte written before it.
// o_stall rises only while both registers are full and the downstream side
// stalls.
// ----------------------------------------------------------------------------
module ones_complement_checksum_engine
    import occe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [5:0]  i_word_offset,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_data,
    output logic        o_bad_offset
);

    t_item   in_item;
    t_item   held_item;
    t_result core_result;
    t_result out_result;
    logic    held_valid;
    logic    out_valid;
    logic    advance;
    logic    accept;

    // Handshake: move the held word on whenever the result register frees
    assign advance = held_valid && (!out_valid || !i_stall);
    assign o_stall = held_valid && !advance;
    assign accept  = i_valid && !o_stall;

    assign in_item.operation   = i_operation;
    assign in_item.word_offset = i_word_offset;
    assign in_item.write_data  = i_write_data;

    occe_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_drain (advance),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    occe_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (core_result)
    );

    occe_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_take   (out_valid && !i_stall),
        .i_result (core_result),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_valid      = out_valid;
    assign o_read_data  = out_result.read_data;
    assign o_bad_offset = out_result.bad_offset;

endmodule

// File: sv/occe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occe_checker
// Port-level checks on the checksum engine: latency, back-pressure and
// result hold while stalled.
// ----------------------------------------------------------------------------
`include "ones_complement_checksum_engine_macros.svh"

module occe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_read_data,
    input logic        o_bad_offset
);

    // An accepted word is followed by a result on the port once it has passed the input register
    `OCCE_ASSERT_TWO(a_result_latency, i_valid && !o_stall, o_valid)

    // Back-pressure upstream only while a result waits on a stalled output
    `OCCE_ASSERT_SAME(a_stall_cause, o_stall, o_valid && i_stall)

    // Hold a stalled result word
    `OCCE_ASSERT_NEXT(a_result_hold, o_valid && i_stall,
                      o_valid && $stable(o_read_data) && $stable(o_bad_offset))

endmodule

bind ones_complement_checksum_engine occe_checker u_occe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_read_data  (o_read_data),
    .o_bad_offset (o_bad_offset)
);
